// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros : assertion shorthands for the ramp generator
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FCLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fclr_pkg.sv -----
// ----------------------------------------------------------------------------
// fclr_pkg : shared constants and types of the five channel linear ramp
// Field widths, request and register codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package fclr_pkg;

  localparam int MAX_PARTICLES = 4096;
  localparam int PCOUNT_MAX    = (MAX_PARTICLES < 8191) ? MAX_PARTICLES : 8191;
  localparam int FRAC_BITS     = 16;
  localparam int NCH           = 5;

  localparam int VAL_W    = 32;
  localparam int LVL_W    = 17;
  localparam int DUR_W    = 16;
  localparam int TC_W     = 8;
  localparam int CAP_W    = 13;
  localparam int PLANE_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CH_W     = 3;

  // retarget difference and its divider
  localparam int DIFF_W    = VAL_W + 1;
  localparam int DIV_CNT_W = $clog2(DIFF_W);

  // report arithmetic widths
  localparam int CNT_PROD_W   = CAP_W + 1 + VAL_W;
  localparam int CNT_SH_W     = CNT_PROD_W - FRAC_BITS;
  localparam int PLANE_SPAN_W = PLANE_W + 1;
  localparam int PLANE_PROD_W = PLANE_SPAN_W + VAL_W;
  localparam int PLANE_SUM_W  = PLANE_PROD_W + 1;
  localparam int PLANE_SH_W   = PLANE_SUM_W - FRAC_BITS;

  // request codes
  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_RETARGET = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SNOW_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR       = 2'd3;

  // channel numbers
  localparam logic [CH_W-1:0] CH_FIRST     = 3'd0;
  localparam logic [CH_W-1:0] CH_VEL_LAST  = 3'd2;
  localparam logic [CH_W-1:0] CH_INTENSITY = 3'd3;
  localparam logic [CH_W-1:0] CH_OPACITY   = 3'd4;
  localparam logic [CH_W-1:0] CH_LAST      = 3'd4;

  localparam logic [PLANE_W-1:0] NEAR_RESET = 16'hFFFF;
  localparam logic [PLANE_W-1:0] FAR_RESET  = 16'hFE00;

  typedef struct packed {
    logic            capture;
    logic            load;
    logic            div_start;
    logic            div_wr;
    logic            ramp_end;
    logic            tick_dec;
    logic            tick_snap;
    logic            tick_mul;
    logic            tick_add;
    logic            mul_cnt;
    logic            mul_plane;
    logic            out_load;
    logic            acc_wr;
    logic            acc_val;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       same;
    logic       dur_zero;
    logic       ticks_zero;
    logic       tc_lt;
    logic       tc_zero;
    logic       snow;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

// ----- rtl/core/fclr_div.sv -----
// ----------------------------------------------------------------------------
// fclr_div : signed by unsigned restoring divider
// One quotient bit per cycle, truncates toward zero, low 32 bits out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fclr_div import fclr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIFF_W-1:0] dividend_i,
  input  logic [DUR_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic [VAL_W-1:0]         quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 neg_q;
  logic [DUR_W-1:0]     div_q;
  logic [DUR_W-1:0]     rem_q;
  logic [DIFF_W-1:0]    quo_q;

  logic [DIFF_W-1:0]    mag;
  logic [DUR_W:0]       shifted;
  logic [DUR_W:0]       trial;
  logic                 fits;

  assign mag     = dividend_i[DIFF_W-1] ? DIFF_W'(-dividend_i) : DIFF_W'(dividend_i);
  assign shifted = {rem_q, quo_q[DIFF_W-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = (shifted >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIFF_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIFF_W-1];
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DUR_W-1:0] : shifted[DUR_W-1:0];
      quo_q <= {quo_q[DIFF_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q[VAL_W-1:0] + 1'b1) : quo_q[VAL_W-1:0];

  `FCLR_ASSERT_IMP(a_div_start_idle, start_i, !busy_q, "divider restarted while busy")

endmodule

// ----- rtl/core/fclr_dp.sv -----
// ----------------------------------------------------------------------------
// fclr_dp : ramp generator datapath
// Configuration, item capture, channel state, divider, multipliers and the
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fclr_dp import fclr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [1:0]           req_type_i,
  input  logic [VAL_W-1:0]     new_vel_x_i,
  input  logic [VAL_W-1:0]     new_vel_y_i,
  input  logic [VAL_W-1:0]     new_vel_z_i,
  input  logic [LVL_W-1:0]     new_intensity_i,
  input  logic [LVL_W-1:0]     new_opacity_i,
  input  logic [DUR_W-1:0]     ramp_duration_i,
  input  logic [TC_W-1:0]      tick_count_i,
  input  logic                 out_stall_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  output logic [VAL_W-1:0]     out_vel_x_o,
  output logic [VAL_W-1:0]     out_vel_y_o,
  output logic [VAL_W-1:0]     out_vel_z_o,
  output logic [VAL_W-1:0]     out_intensity_o,
  output logic [VAL_W-1:0]     out_opacity_o,
  output logic [CAP_W-1:0]     particle_count_o,
  output logic [PLANE_W-1:0]   plane_current_o,
  output logic                 draw_enable_o,
  output logic                 accepted_o
);

  // configuration
  logic                      snow_q;
  logic [CAP_W-1:0]          cap_q;
  logic signed [PLANE_W-1:0] near_q;
  logic signed [PLANE_W-1:0] far_q;

  // captured item
  logic [1:0]       req_q;
  logic [VAL_W-1:0] nv_q [NCH];
  logic [DUR_W-1:0] dur_q;
  logic [TC_W-1:0]  tc_q;

  // ramp state
  logic [VAL_W-1:0] cur_q  [NCH];
  logic [VAL_W-1:0] step_q [NCH];
  logic [VAL_W-1:0] tgt_q  [NCH];
  logic [DUR_W-1:0] ticks_q;

  logic [VAL_W-1:0]               tick_prod_q;
  logic signed [CNT_PROD_W-1:0]   cnt_prod_q;
  logic signed [PLANE_PROD_W-1:0] plane_prod_q;
  logic                           acc_q;
  logic                           out_valid_q;

  logic signed [DIFF_W-1:0]       diff;
  logic                           div_done;
  logic [VAL_W-1:0]               quot;
  logic signed [PLANE_SPAN_W-1:0] span;
  logic signed [CNT_SH_W-1:0]     cnt_sh;
  logic [CAP_W-1:0]               cnt_sat;
  logic signed [PLANE_SUM_W-1:0]  plane_sum;
  logic signed [PLANE_SH_W-1:0]   plane_sh;
  logic [PLANE_W-1:0]             plane_sat;
  logic                           draw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snow_q <= 1'b1;
      cap_q  <= '0;
      near_q <= NEAR_RESET;
      far_q  <= FAR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SNOW_MODE: snow_q <= cfg_data_i[0];
        CFG_CAPACITY:  cap_q  <= cfg_data_i[CAP_W-1:0];
        CFG_NEAR:      near_q <= cfg_data_i[PLANE_W-1:0];
        CFG_FAR:       far_q  <= cfg_data_i[PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= req_type_i;
      nv_q[0]  <= new_vel_x_i;
      nv_q[1]  <= new_vel_y_i;
      nv_q[2]  <= new_vel_z_i;
      nv_q[3]  <= VAL_W'(new_intensity_i);
      nv_q[4]  <= VAL_W'(new_opacity_i);
      dur_q    <= ramp_duration_i;
      tc_q     <= tick_count_i;
    end
  end

  assign diff = DIFF_W'($signed(nv_q[cmd_i.ch])) - DIFF_W'($signed(cur_q[cmd_i.ch]));

  fclr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (diff),
    .divisor_i  (dur_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        cur_q[i]  <= '0;
        step_q[i] <= '0;
        tgt_q[i]  <= '0;
      end
      ticks_q <= '0;
    end else begin
      if (cmd_i.load) begin
        for (int i = 0; i < NCH; i++) begin
          cur_q[i]  <= nv_q[i];
          tgt_q[i]  <= nv_q[i];
          step_q[i] <= '0;
        end
        ticks_q <= '0;
      end
      if (cmd_i.div_wr) begin
        step_q[cmd_i.ch] <= quot;
        tgt_q[cmd_i.ch]  <= nv_q[cmd_i.ch];
      end
      if (cmd_i.ramp_end) begin
        if (snow_q) begin
          ticks_q <= dur_q;
        end else begin
          // rain sets intensity and opacity at once
          cur_q[CH_INTENSITY] <= nv_q[CH_INTENSITY];
          cur_q[CH_OPACITY]   <= nv_q[CH_OPACITY];
          ticks_q             <= '0;
        end
      end
      if (cmd_i.tick_dec) begin
        ticks_q <= ticks_q - DUR_W'(tc_q);
      end
      if (cmd_i.tick_snap) begin
        for (int i = 0; i < NCH; i++) begin
          cur_q[i] <= tgt_q[i];
        end
        ticks_q <= '0;
      end
      if (cmd_i.tick_add) begin
        cur_q[cmd_i.ch] <= cur_q[cmd_i.ch] + tick_prod_q;
      end
    end
  end

  assign span = PLANE_SPAN_W'(far_q) - PLANE_SPAN_W'(near_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_mul) begin
      tick_prod_q <= step_q[cmd_i.ch] * VAL_W'(tc_q);
    end
    if (cmd_i.mul_cnt) begin
      cnt_prod_q <= $signed({1'b0, cap_q}) * $signed(cur_q[CH_INTENSITY]);
    end
    if (cmd_i.mul_plane) begin
      plane_prod_q <= span * $signed(cur_q[CH_OPACITY]);
    end
    if (cmd_i.acc_wr) begin
      acc_q <= cmd_i.acc_val;
    end
  end

  // floor shift and saturation of the report values
  assign cnt_sh    = CNT_SH_W'(cnt_prod_q >>> FRAC_BITS);
  assign plane_sum = PLANE_SUM_W'(near_q) + PLANE_SUM_W'(plane_prod_q);
  assign plane_sh  = PLANE_SH_W'(plane_sum >>> FRAC_BITS);

  always_comb begin
    if (cnt_sh < 0) begin
      cnt_sat = '0;
    end else if (cnt_sh > CNT_SH_W'(PCOUNT_MAX)) begin
      cnt_sat = CAP_W'(PCOUNT_MAX);
    end else begin
      cnt_sat = cnt_sh[CAP_W-1:0];
    end
    if (plane_sh < -PLANE_SH_W'(32768)) begin
      plane_sat = 16'h8000;
    end else if (plane_sh > PLANE_SH_W'(32767)) begin
      plane_sat = 16'h7FFF;
    end else begin
      plane_sat = plane_sh[PLANE_W-1:0];
    end
    draw = snow_q && (cnt_sat != '0) && (plane_sh < PLANE_SH_W'(near_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_vel_x_o      <= cur_q[0];
      out_vel_y_o      <= cur_q[1];
      out_vel_z_o      <= cur_q[2];
      out_intensity_o  <= cur_q[CH_INTENSITY];
      out_opacity_o    <= cur_q[CH_OPACITY];
      particle_count_o <= cnt_sat;
      plane_current_o  <= plane_sat;
      draw_enable_o    <= draw;
      accepted_o       <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.req        = req_q;
    sts_o.same       = (nv_q[0] == tgt_q[0]) && (nv_q[1] == tgt_q[1]) &&
                       (nv_q[2] == tgt_q[2]) &&
                       (nv_q[CH_INTENSITY] == cur_q[CH_INTENSITY]) &&
                       (nv_q[CH_OPACITY] == cur_q[CH_OPACITY]);
    sts_o.dur_zero   = (dur_q == '0);
    sts_o.ticks_zero = (ticks_q == '0);
    sts_o.tc_lt      = (DUR_W'(tc_q) < ticks_q);
    sts_o.tc_zero    = (tc_q == '0);
    sts_o.snow       = snow_q;
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  `FCLR_ASSERT_IMP(a_no_overwrite, cmd_i.out_load, !(out_valid_q && out_stall_i),
                   "result overwritten before taken")
  `FCLR_ASSERT_IMP(a_step_from_div, cmd_i.div_wr, div_done,
                   "step written without a finished quotient")

endmodule

// ----- rtl/core/fclr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fclr_ctrl : ramp generator sequencer
// Decodes the captured request and walks the channels through the divider
// or the tick multiplier, then runs the report products.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fclr_ctrl import fclr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_DIV_GO    = 4'd2;
  localparam logic [3:0] S_DIV_WAIT  = 4'd3;
  localparam logic [3:0] S_TICK_MUL  = 4'd4;
  localparam logic [3:0] S_TICK_ADD  = 4'd5;
  localparam logic [3:0] S_MUL_CNT   = 4'd6;
  localparam logic [3:0] S_MUL_PLANE = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic [CH_W-1:0] ch_last;

  assign ch_last    = sts_i.snow ? CH_LAST : CH_VEL_LAST;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o    = '0;
    cmd_o.ch = ch_q;
    state_d  = state_q;
    ch_d     = ch_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.acc_wr = 1'b1;
        state_d      = S_MUL_CNT;
        unique case (sts_i.req)
          REQ_LOAD: begin
            cmd_o.load    = 1'b1;
            cmd_o.acc_val = 1'b1;
          end
          REQ_RETARGET: begin
            if (!sts_i.dur_zero && !sts_i.same) begin
              cmd_o.acc_val = 1'b1;
              ch_d          = CH_FIRST;
              state_d       = S_DIV_GO;
            end
          end
          REQ_TICK: begin
            if (sts_i.snow && !sts_i.ticks_zero) begin
              cmd_o.acc_val = !sts_i.tc_zero;
              if (sts_i.tc_lt) begin
                cmd_o.tick_dec = 1'b1;
                ch_d           = CH_FIRST;
                state_d        = S_TICK_MUL;
              end else begin
                cmd_o.tick_snap = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          if (ch_q == ch_last) begin
            cmd_o.ramp_end = 1'b1;
            state_d        = S_MUL_CNT;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_TICK_MUL: begin
        cmd_o.tick_mul = 1'b1;
        state_d        = S_TICK_ADD;
      end
      S_TICK_ADD: begin
        cmd_o.tick_add = 1'b1;
        if (ch_q == CH_LAST) begin
          state_d = S_MUL_CNT;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_TICK_MUL;
        end
      end
      S_MUL_CNT: begin
        cmd_o.mul_cnt = 1'b1;
        state_d       = S_MUL_PLANE;
      end
      S_MUL_PLANE: begin
        cmd_o.mul_plane = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= CH_FIRST;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  `FCLR_ASSERT_NXT(a_accept_decode, in_valid_i && !in_stall_o, state_q == S_DECODE,
                   "accepted item not decoded next")
  `FCLR_ASSERT_IMP(a_ch_range, state_q != S_IDLE, ch_q <= CH_LAST,
                   "channel counter out of range")

endmodule

// ----- rtl/core/five_channel_linear_ramp.sv -----
// ----------------------------------------------------------------------------
// five_channel_linear_ramp : five channel 16.16 linear ramp generator
// Keeps velocity x/y/z, intensity and opacity and answers every request
// (load, retarget, tick) with one item holding the current values, the
// particle count, the plane depth and the draw flag. One request is worked
// at a time. A retarget divides each ramping channel in turn on one shared
// divider that yields a quotient bit per cycle: five channels in snow mode
// and three in rain mode. A tick does a multiply and an add per channel; a
// snap tick, a load or an ignored request goes straight to the report
// products. The result sits in an output register, so the next request can
// be taken while it waits to be read. The user must write configuration
// only while no request is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module five_channel_linear_ramp import fclr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [VAL_W-1:0]     new_vel_x_i,
  input  logic [VAL_W-1:0]     new_vel_y_i,
  input  logic [VAL_W-1:0]     new_vel_z_i,
  input  logic [LVL_W-1:0]     new_intensity_i,
  input  logic [LVL_W-1:0]     new_opacity_i,
  input  logic [DUR_W-1:0]     ramp_duration_i,
  input  logic [TC_W-1:0]      tick_count_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VAL_W-1:0]     out_vel_x_o,
  output logic [VAL_W-1:0]     out_vel_y_o,
  output logic [VAL_W-1:0]     out_vel_z_o,
  output logic [VAL_W-1:0]     out_intensity_o,
  output logic [VAL_W-1:0]     out_opacity_o,
  output logic [CAP_W-1:0]     particle_count_o,
  output logic [PLANE_W-1:0]   plane_current_o,
  output logic                 draw_enable_o,
  output logic                 accepted_o
);

  cmd_t cmd;
  sts_t sts;

  fclr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fclr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .new_vel_x_i      (new_vel_x_i),
    .new_vel_y_i      (new_vel_y_i),
    .new_vel_z_i      (new_vel_z_i),
    .new_intensity_i  (new_intensity_i),
    .new_opacity_i    (new_opacity_i),
    .ramp_duration_i  (ramp_duration_i),
    .tick_count_i     (tick_count_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_vel_x_o      (out_vel_x_o),
    .out_vel_y_o      (out_vel_y_o),
    .out_vel_z_o      (out_vel_z_o),
    .out_intensity_o  (out_intensity_o),
    .out_opacity_o    (out_opacity_o),
    .particle_count_o (particle_count_o),
    .plane_current_o  (plane_current_o),
    .draw_enable_o    (draw_enable_o),
    .accepted_o       (accepted_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : five channel linear ramp generator
// Drives load, retarget and tick requests through the valid/stall input,
// predicts every report from a local model of the ramp state and compares
// each report field by field. Register settings change between phases,
// and sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  import fclr_pkg::*;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         SETTLE_CYCLES  = 250;
  localparam int         NUM_PHASES     = 8;
  localparam int         PHASE_ITEMS    = 75;

  typedef struct {
    logic [1:0]       kind;
    logic [VAL_W-1:0] vx, vy, vz;
    logic [LVL_W-1:0] inten, opac;
    logic [DUR_W-1:0] dur;
    logic [TC_W-1:0]  ticks;
  } ramp_req_t;

  typedef struct {
    logic [VAL_W-1:0]   vx, vy, vz, inten, opac;
    logic [CAP_W-1:0]   count;
    logic [PLANE_W-1:0] plane;
    logic               draw;
    logic               acc;
  } ramp_report_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [CFG_W-1:0]     cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           req_type_i      = '0;
  logic [VAL_W-1:0]     new_vel_x_i     = '0;
  logic [VAL_W-1:0]     new_vel_y_i     = '0;
  logic [VAL_W-1:0]     new_vel_z_i     = '0;
  logic [LVL_W-1:0]     new_intensity_i = '0;
  logic [LVL_W-1:0]     new_opacity_i   = '0;
  logic [DUR_W-1:0]     ramp_duration_i = '0;
  logic [TC_W-1:0]      tick_count_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [VAL_W-1:0]     out_vel_x_o;
  logic [VAL_W-1:0]     out_vel_y_o;
  logic [VAL_W-1:0]     out_vel_z_o;
  logic [VAL_W-1:0]     out_intensity_o;
  logic [VAL_W-1:0]     out_opacity_o;
  logic [CAP_W-1:0]     particle_count_o;
  logic [PLANE_W-1:0]   plane_current_o;
  logic                 draw_enable_o;
  logic                 accepted_o;

  five_channel_linear_ramp DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .new_vel_x_i     (new_vel_x_i),
    .new_vel_y_i     (new_vel_y_i),
    .new_vel_z_i     (new_vel_z_i),
    .new_intensity_i (new_intensity_i),
    .new_opacity_i   (new_opacity_i),
    .ramp_duration_i (ramp_duration_i),
    .tick_count_i    (tick_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_vel_x_o     (out_vel_x_o),
    .out_vel_y_o     (out_vel_y_o),
    .out_vel_z_o     (out_vel_z_o),
    .out_intensity_o (out_intensity_o),
    .out_opacity_o   (out_opacity_o),
    .particle_count_o(particle_count_o),
    .plane_current_o (plane_current_o),
    .draw_enable_o   (draw_enable_o),
    .accepted_o      (accepted_o)
  );

  ramp_req_t    pending_reqs[$];
  ramp_report_t expected_reports[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int n_requests     = 0;
  int n_checked      = 0;
  int n_ramps        = 0;
  int n_snaps        = 0;
  int quiet_cycles   = 0;

  // local copy of the ramp state and registers
  logic                      mdl_snow;
  logic [CAP_W-1:0]          mdl_cap;
  logic signed [PLANE_W-1:0] mdl_near;
  logic signed [PLANE_W-1:0] mdl_far;
  logic [VAL_W-1:0]          cur_val[NCH];
  logic [VAL_W-1:0]          step_val[NCH];
  logic [VAL_W-1:0]          target_val[NCH];
  logic [DUR_W-1:0]          ticks_left;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_ramp_state();
    int i;
    mdl_snow   = 1'b1;
    mdl_cap    = '0;
    mdl_near   = NEAR_RESET;
    mdl_far    = FAR_RESET;
    ticks_left = '0;
    for (i = 0; i < NCH; i++) begin
      cur_val[i]    = '0;
      step_val[i]   = '0;
      target_val[i] = '0;
    end
  endfunction

  // exact difference, truncated toward zero, low 32 bits kept
  function automatic logic [VAL_W-1:0] ramp_step(logic [VAL_W-1:0] tgt,
                                                 logic [VAL_W-1:0] cur,
                                                 logic [DUR_W-1:0] dur);
    longint diff;
    diff = longint'($signed(tgt)) - longint'($signed(cur));
    return 32'(diff / longint'(dur));
  endfunction

  function automatic ramp_report_t predict_ramp_report(ramp_req_t r);
    logic [VAL_W-1:0] nv[NCH];
    logic             same;
    logic             acc;
    longint           cnt, nearv, farv, plane, plane_sat;
    ramp_report_t     rep;
    int               i;
    nv[0] = r.vx;
    nv[1] = r.vy;
    nv[2] = r.vz;
    nv[3] = 32'(r.inten);
    nv[4] = 32'(r.opac);
    acc   = 1'b0;
    case (r.kind)
      REQ_LOAD: begin
        for (i = 0; i < NCH; i++) begin
          cur_val[i]    = nv[i];
          target_val[i] = nv[i];
          step_val[i]   = '0;
        end
        ticks_left = '0;
        acc        = 1'b1;
      end
      REQ_RETARGET: begin
        same = nv[0] == target_val[0] && nv[1] == target_val[1] &&
               nv[2] == target_val[2] && nv[3] == cur_val[3] && nv[4] == cur_val[4];
        if (r.dur != 0 && !same) begin
          for (i = 0; i < 3; i++) begin
            target_val[i] = nv[i];
            step_val[i]   = ramp_step(nv[i], cur_val[i], r.dur);
          end
          if (mdl_snow) begin
            for (i = 3; i < NCH; i++) begin
              step_val[i]   = ramp_step(nv[i], cur_val[i], r.dur);
              target_val[i] = nv[i];
            end
            ticks_left = r.dur;
            n_ramps++;
          end else begin
            // rain: levels jump, velocities stay put
            cur_val[3] = nv[3];
            cur_val[4] = nv[4];
            ticks_left = '0;
          end
          acc = 1'b1;
        end
      end
      REQ_TICK: begin
        if (mdl_snow && ticks_left != 0) begin
          if (16'(r.ticks) < ticks_left) begin
            for (i = 0; i < NCH; i++) cur_val[i] = cur_val[i] + step_val[i] * 32'(r.ticks);
            ticks_left = ticks_left - 16'(r.ticks);
          end else begin
            for (i = 0; i < NCH; i++) cur_val[i] = target_val[i];
            ticks_left = '0;
            n_snaps++;
          end
          acc = r.ticks != 0;
        end
      end
      default: ;
    endcase

    cnt   = (longint'(mdl_cap) * longint'($signed(cur_val[3]))) >>> FRAC_BITS;
    nearv = longint'(mdl_near);
    farv  = longint'(mdl_far);
    plane = (nearv + (farv - nearv) * longint'($signed(cur_val[4]))) >>> FRAC_BITS;
    if (cnt < 0) cnt = 0;
    if (cnt > PCOUNT_MAX) cnt = PCOUNT_MAX;
    plane_sat = plane;
    if (plane_sat < -32768) plane_sat = -32768;
    if (plane_sat > 32767) plane_sat = 32767;

    rep.vx    = cur_val[0];
    rep.vy    = cur_val[1];
    rep.vz    = cur_val[2];
    rep.inten = cur_val[3];
    rep.opac  = cur_val[4];
    rep.count = 13'(cnt);
    rep.plane = 16'(plane_sat);
    rep.draw  = mdl_snow && cnt > 0 && plane < nearv;
    rep.acc   = acc;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    ramp_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        req_type_i      <= nxt.kind;
        new_vel_x_i     <= nxt.vx;
        new_vel_y_i     <= nxt.vy;
        new_vel_z_i     <= nxt.vz;
        new_intensity_i <= nxt.inten;
        new_opacity_i   <= nxt.opac;
        ramp_duration_i <= nxt.dur;
        tick_count_i    <= nxt.ticks;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: follows register writes, predicts on each accepted request,
  // checks each accepted report against the oldest prediction
  always @(posedge clk_i) begin
    ramp_req_t    req;
    ramp_report_t exp_r;
    if (!rst_ni) begin
      reset_ramp_state();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SNOW_MODE: mdl_snow = cfg_data_i[0];
          CFG_CAPACITY:  mdl_cap  = cfg_data_i[CAP_W-1:0];
          CFG_NEAR:      mdl_near = cfg_data_i;
          CFG_FAR:       mdl_far  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        req.kind  = req_type_i;
        req.vx    = new_vel_x_i;
        req.vy    = new_vel_y_i;
        req.vz    = new_vel_z_i;
        req.inten = new_intensity_i;
        req.opac  = new_opacity_i;
        req.dur   = ramp_duration_i;
        req.ticks = tick_count_i;
        expected_reports.push_back(predict_ramp_report(req));
        n_requests++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("report arrived with no request outstanding");
          mismatches++;
        end else begin
          exp_r = expected_reports.pop_front();
          check_field("out_vel_x", exp_r.vx, out_vel_x_o);
          check_field("out_vel_y", exp_r.vy, out_vel_y_o);
          check_field("out_vel_z", exp_r.vz, out_vel_z_o);
          check_field("out_intensity", exp_r.inten, out_intensity_o);
          check_field("out_opacity", exp_r.opac, out_opacity_o);
          check_field("particle_count", 32'(exp_r.count), 32'(particle_count_o));
          check_field("plane_current", 32'(exp_r.plane), 32'(plane_current_o));
          check_field("draw_enable", 32'(exp_r.draw), 32'(draw_enable_o));
          check_field("accepted", 32'(exp_r.acc), 32'(accepted_o));
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic program_regs(input logic snow, input int cap,
                              input logic [PLANE_W-1:0] near_v,
                              input logic [PLANE_W-1:0] far_v);
    write_reg(CFG_SNOW_MODE, CFG_W'(snow));
    write_reg(CFG_CAPACITY, CFG_W'(cap));
    write_reg(CFG_NEAR, near_v);
    write_reg(CFG_FAR, far_v);
    @(negedge clk_i);
  endtask

  // wait until every request has been answered
  task automatic drain();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_req(input logic [1:0] kind, input logic [VAL_W-1:0] vx,
                          input logic [VAL_W-1:0] vy, input logic [VAL_W-1:0] vz,
                          input logic [LVL_W-1:0] inten, input logic [LVL_W-1:0] opac,
                          input logic [DUR_W-1:0] dur, input logic [TC_W-1:0] ticks);
    ramp_req_t r;
    r.kind  = kind;
    r.vx    = vx;
    r.vy    = vy;
    r.vz    = vz;
    r.inten = inten;
    r.opac  = opac;
    r.dur   = dur;
    r.ticks = ticks;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [VAL_W-1:0] rand_vel();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(32'h1F_FFFF) - 32'h10_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] rand_level();
    case ($urandom_range(7))
      0: return '0;
      1: return 17'h10000;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // mostly short ramps so that ticks reach the targets
  function automatic logic [DUR_W-1:0] rand_dur();
    case ($urandom_range(9))
      0: return 16'($urandom_range(1, 65535));
      1, 2: return 16'($urandom_range(1, 8));
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic ramp_req_t rand_req(input logic [1:0] kind);
    ramp_req_t r;
    r.kind  = kind;
    r.vx    = rand_vel();
    r.vy    = rand_vel();
    r.vz    = rand_vel();
    r.inten = rand_level();
    r.opac  = rand_level();
    r.dur   = 16'($urandom);
    r.ticks = 8'($urandom);
    return r;
  endfunction

  task automatic gen_random(input int n);
    ramp_req_t r, t;
    int        made, j, k;
    made = 0;
    while (made < n) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          // retarget, then a run of ticks along the ramp
          r = rand_req(REQ_RETARGET);
          r.dur = rand_dur();
          pending_reqs.push_back(r);
          k = $urandom_range(1, 6);
          for (j = 0; j < k; j++) begin
            t = rand_req(REQ_TICK);
            if ($urandom_range(3) != 0)
              t.ticks = 8'($urandom_range(0, (r.dur > 255) ? 255 : r.dur));
            pending_reqs.push_back(t);
          end
          made += k + 1;
          if ($urandom_range(1) == 1) begin
            t = rand_req(REQ_TICK);
            t.ticks = 8'hFF;
            pending_reqs.push_back(t);
            made++;
          end
          // same retarget again, dropped once the ramp has landed
          if ($urandom_range(3) == 0) begin
            pending_reqs.push_back(r);
            made++;
          end
        end
        9, 10, 11, 12: begin
          r = rand_req(REQ_LOAD);
          pending_reqs.push_back(r);
          made++;
          if ($urandom_range(2) == 0) begin
            r.kind = REQ_RETARGET;
            r.dur  = rand_dur();
            pending_reqs.push_back(r);
            made++;
          end
        end
        13, 14, 15, 16: begin
          pending_reqs.push_back(rand_req(REQ_TICK));
          made++;
        end
        17: begin
          pending_reqs.push_back(rand_req(REQ_UNUSED));
          made++;
        end
        18: begin
          r = rand_req(REQ_RETARGET);
          r.dur = '0;
          pending_reqs.push_back(r);
          made++;
        end
        default: begin
          pending_reqs.push_back(rand_req(REQ_RETARGET));
          made++;
        end
      endcase
    end
  endtask

  initial begin
    int p;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    program_regs(1'b1, 4096, 16'hFFFF, 16'hFE00);
    push_req(REQ_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 17'h10000, 17'h10000,
             16'hFFFF, 8'hFF);
    // same values as stored: dropped
    push_req(REQ_RETARGET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 17'h10000, 17'h10000,
             16'd5, 8'h00);
    push_req(REQ_RETARGET, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'h0, 17'h0,
             16'd0, 8'h00);
    // widest differences
    push_req(REQ_RETARGET, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'h0, 17'h0,
             16'd3, 8'h00);
    push_req(REQ_TICK, 32'h0, 32'h0, 32'h0, 17'h0, 17'h0, 16'h0, 8'd0);
    push_req(REQ_TICK, 32'h0, 32'h0, 32'h0, 17'h0, 17'h0, 16'h0, 8'd1);
    push_req(REQ_TICK, 32'h0, 32'h0, 32'h0, 17'h0, 17'h0, 16'h0, 8'd2);
    push_req(REQ_TICK, 32'h0, 32'h0, 32'h0, 17'h0, 17'h0, 16'h0, 8'd5);
    push_req(REQ_RETARGET, 32'h0001_8000, 32'hFFFE_0000, 32'h7FFF_FFFF, 17'h10000,
             17'h08000, 16'hFFFF, 8'h00);
    push_req(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h10000, 17'h10000,
             16'hFFFF, 8'hFF);
    push_req(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h0FFFF, 17'h0FFFF,
             16'hFFFF, 8'hFF);
    push_req(REQ_UNUSED, 32'h0, 32'h0, 32'h0, 17'h0, 17'h0, 16'd7, 8'd7);
    push_req(REQ_RETARGET, 32'h1234_5678, 32'hEDCB_A988, 32'h0, 17'h0FFFF, 17'h00001,
             16'd1, 8'h00);
    // overshooting tick lands on the targets
    push_req(REQ_TICK, 32'h0, 32'h0, 32'h0, 17'h0, 17'h0, 16'h0, 8'hFF);
    push_req(REQ_LOAD, 32'h0, 32'h0, 32'h0, 17'h0, 17'h0, 16'h0, 8'h00);
    drain();

    program_regs(1'b0, 4096, 16'h7FFF, 16'h8000);
    push_req(REQ_RETARGET, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 17'h10000,
             17'h10000, 16'd100, 8'd0);
    push_req(REQ_RETARGET, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 17'h10000,
             17'h10000, 16'd100, 8'd0);
    push_req(REQ_TICK, 32'h0, 32'h0, 32'h0, 17'h0, 17'h0, 16'h0, 8'd10);
    push_req(REQ_RETARGET, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 17'h0, 17'h08000,
             16'hFFFF, 8'hFF);
    push_req(REQ_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h10000, 17'h0,
             16'h0, 8'h0);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs(1'b1, 4096, 16'hFFFF, 16'hFE00);
        1: program_regs(1'b1, 0, 16'h8000, 16'h7FFF);
        2: program_regs(1'b0, 4096, 16'h7FFF, 16'h8000);
        4: program_regs(1'b1, 1, 16'h7FFF, 16'h8000);
        7: program_regs(1'b1, 4096, 16'h8000, 16'h7FFF);
        default: program_regs(p != 5, $urandom_range(4096), 16'($urandom), 16'($urandom));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      gen_random(PHASE_ITEMS);
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("%0d requests answered, %0d reports compared, %0d register settings",
             n_requests, n_checked, NUM_PHASES + 2);
    $display("%0d snow ramps started, %0d ticks landed on the targets", n_ramps, n_snaps);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- five_channel_linear_ramp.f -----
+incdir+rtl/core
rtl/core/fclr_pkg.sv
rtl/core/fclr_div.sv
rtl/core/fclr_dp.sv
rtl/core/fclr_ctrl.sv
rtl/core/five_channel_linear_ramp.sv
tb/testbench.sv
